// File: rtl/core/motor_angle_pid_with_fault_watch_top_assert.svh
// Assertion macros shared by the angle PID block
`ifndef MOTOR_ANGLE_PID_WITH_FAULT_WATCH_TOP_ASSERT_SVH
`define MOTOR_ANGLE_PID_WITH_FAULT_WATCH_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MAPID_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// next-cycle implication
`define MAPID_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define MAPID_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MAPID_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/mapid_pkg.sv
// Types and constants for the angle PID block with fault watchdog
package mapid_pkg;

    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 16;
    localparam int SP_W      = 9;
    localparam int ANGLE_W   = 16;
    localparam int ERR_W     = 18;
    localparam int DIFF_W    = 19;
    localparam int DRIVE_W   = 11;
    localparam int CNT_W     = 8;
    localparam int STUCK_BAND = 5;

    localparam logic signed [SP_W:0] SP_HIGH = 10'sd180;
    localparam logic signed [SP_W:0] SP_LOW  = -10'sd180;
    localparam logic signed [SP_W:0] SP_WRAP = 10'sd360;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        REG_SETPOINT        = 3'd0,
        REG_GAIN_P          = 3'd1,
        REG_GAIN_I          = 3'd2,
        REG_GAIN_D          = 3'd3,
        REG_DRIVE_LIMIT     = 3'd4,
        REG_STUCK_LIMIT     = 3'd5,
        REG_WRONG_WAY_LIMIT = 3'd6,
        REG_CHECK_WINDOW    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [SP_W-1:0] setpoint;
        logic [GAIN_W-1:0]      gain_p;
        logic [GAIN_W-1:0]      gain_i;
        logic [GAIN_W-1:0]      gain_d;
        logic [DRIVE_W-1:0]     drive_limit;
        logic [CNT_W-1:0]       stuck_limit;
        logic [CNT_W-1:0]       wrong_way_limit;
        logic [CNT_W-1:0]       check_window;
    } cfg_t;

    localparam cfg_t CFG_RST = '{
        setpoint:        9'sd180,
        gain_p:          16'd7680,
        gain_i:          16'd1182,
        gain_d:          16'd12480,
        drive_limit:     11'd1024,
        stuck_limit:     8'd30,
        wrong_way_limit: 8'd10,
        check_window:    8'd100
    };

    // nonzero setpoint write reloads the direction flag
    typedef struct packed {
        logic load;
        logic value;
    } dir_load_t;

    // per-sample motion observations for the watchdog
    typedef struct packed {
        logic in_band;
        logic same;
        logic rising;
        logic falling;
        logic forward;
    } motion_t;

endpackage

// File: rtl/core/mapid_cfg.sv
// APB configuration registers of the angle PID block
module mapid_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mapid_pkg::ADDR_W-1:0]  paddr,
    input  logic [mapid_pkg::DATA_W-1:0]  pwdata,
    output logic [mapid_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output mapid_pkg::cfg_t               cfg,
    output mapid_pkg::dir_load_t          dir_load
);
    import mapid_pkg::*;

    cfg_t                   cfg_reg, cfg_next;
    reg_idx_t               idx;
    logic                   wr;
    logic signed [SP_W:0]   sp_ext;
    logic signed [SP_W:0]   sp_wrap;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign sp_ext = {pwdata[SP_W-1], pwdata[SP_W-1:0]};

    always_comb begin
        priority if (sp_ext > SP_HIGH) begin
            sp_wrap = sp_ext - SP_WRAP;
        end else if (sp_ext < SP_LOW) begin
            sp_wrap = sp_ext + SP_WRAP;
        end else begin
            sp_wrap = sp_ext;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (wr) begin
            unique case (idx)
                REG_SETPOINT:        cfg_next.setpoint        = sp_wrap[SP_W-1:0];
                REG_GAIN_P:          cfg_next.gain_p          = pwdata[GAIN_W-1:0];
                REG_GAIN_I:          cfg_next.gain_i          = pwdata[GAIN_W-1:0];
                REG_GAIN_D:          cfg_next.gain_d          = pwdata[GAIN_W-1:0];
                REG_DRIVE_LIMIT:     cfg_next.drive_limit     = pwdata[DRIVE_W-1:0];
                REG_STUCK_LIMIT:     cfg_next.stuck_limit     = pwdata[CNT_W-1:0];
                REG_WRONG_WAY_LIMIT: cfg_next.wrong_way_limit = pwdata[CNT_W-1:0];
                REG_CHECK_WINDOW:    cfg_next.check_window    = pwdata[CNT_W-1:0];
            endcase
        end
    end

    // zero setpoint leaves the direction flag alone
    assign dir_load.load  = wr && (idx == REG_SETPOINT) && (sp_wrap != '0);
    assign dir_load.value = !sp_wrap[SP_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (idx)
            REG_SETPOINT:
                prdata = {{(DATA_W-SP_W){cfg_reg.setpoint[SP_W-1]}}, cfg_reg.setpoint};
            REG_GAIN_P:          prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_reg.gain_p};
            REG_GAIN_I:          prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_reg.gain_i};
            REG_GAIN_D:          prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_reg.gain_d};
            REG_DRIVE_LIMIT:     prdata = {{(DATA_W-DRIVE_W){1'b0}}, cfg_reg.drive_limit};
            REG_STUCK_LIMIT:     prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_reg.stuck_limit};
            REG_WRONG_WAY_LIMIT: prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_reg.wrong_way_limit};
            REG_CHECK_WINDOW:    prdata = {{(DATA_W-CNT_W){1'b0}}, cfg_reg.check_window};
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/mapid_wdog.sv
// Stuck and wrong-way watchdog counters with windowed clear
`include "motor_angle_pid_with_fault_watch_top_assert.svh"
module mapid_wdog (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step,
    input  mapid_pkg::cfg_t                   cfg,
    input  mapid_pkg::motion_t                motion,
    input  logic                              drive_nz,
    output logic                              stuck_alarm,
    output logic                              wrong_alarm
);
    import mapid_pkg::*;

    logic [CNT_W-1:0] stuck_cnt_reg, stuck_cnt_next;
    logic [CNT_W-1:0] wrong_cnt_reg, wrong_cnt_next;
    logic [CNT_W-1:0] win_cnt_reg, win_cnt_next;
    logic [CNT_W-1:0] sc, wc;
    logic             wrong_way;

    assign wrong_way = (!motion.forward && motion.rising) ||
                       (motion.forward && motion.falling);

    always_comb begin
        sc          = stuck_cnt_reg;
        stuck_alarm = 1'b0;
        if (drive_nz && !motion.in_band) begin
            if (motion.same && sc != CNT_MAX) begin
                sc = sc + 1'b1;
            end
            if (sc > cfg.stuck_limit) begin
                sc          = '0;
                stuck_alarm = 1'b1;
            end
        end

        wrong_alarm = 1'b0;
        if (wrong_way) begin
            wc = (wrong_cnt_reg != CNT_MAX) ? wrong_cnt_reg + 1'b1 : wrong_cnt_reg;
        end else begin
            wc = '0;
        end
        if (wc > cfg.wrong_way_limit) begin
            wc          = '0;
            wrong_alarm = 1'b1;
        end

        if (win_cnt_reg >= cfg.check_window) begin
            win_cnt_next   = '0;
            stuck_cnt_next = '0;
            wrong_cnt_next = '0;
        end else begin
            win_cnt_next   = win_cnt_reg + 1'b1;
            stuck_cnt_next = sc;
            wrong_cnt_next = wc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stuck_cnt_reg <= '0;
            wrong_cnt_reg <= '0;
            win_cnt_reg   <= '0;
        end else if (step) begin
            stuck_cnt_reg <= stuck_cnt_next;
            wrong_cnt_reg <= wrong_cnt_next;
            win_cnt_reg   <= win_cnt_next;
        end
    end

    `MAPID_ASSERT_NXT(a_stuck_alarm_clears, aclk, aresetn, step && stuck_alarm, stuck_cnt_reg == '0)
    `MAPID_ASSERT_NXT(a_wrong_alarm_clears, aclk, aresetn, step && wrong_alarm, wrong_cnt_reg == '0)
    `MAPID_ASSERT_IMP(a_stuck_alarm_needs_drive, aclk, aresetn, stuck_alarm, drive_nz)

endmodule

// File: rtl/core/motor_angle_pid_with_fault_watch_top.sv
// Throughput: one beat per cycle while m_tready does not hold the output; the integrator
// and error history update at stage 2, the watchdog counters at the output stage.
// Stages: input register, error/integrator, gain products, sum, clamp+watchdog.
// Reset: aresetn synchronous, active low; clears the pipe, history and counters,
// and loads the register defaults.
`include "motor_angle_pid_with_fault_watch_top_assert.svh"
module motor_angle_pid_with_fault_watch_top #(
    parameter int SUM_WIDTH      = 24,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mapid_pkg::ADDR_W-1:0]  paddr,
    input  logic [mapid_pkg::DATA_W-1:0]  pwdata,
    output logic [mapid_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    // angle samples
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [15:0] angle
    // drive results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [10:0] drive, [11] forward, [12] stuck_alarm, [13] wrong_way_alarm, [15:14] zero
    output logic [15:0]                   m_tdata
);
    import mapid_pkg::*;

    localparam int PROD_E_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + SUM_WIDTH;
    localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W    = ((PROD_I_W > PROD_D_W) ? PROD_I_W : PROD_D_W) + 2;
    localparam int MAG_W    = ACC_W - GAIN_FRAC_BITS;

    cfg_t      cfg;
    dir_load_t dir_load;

    mapid_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cfg      (cfg),
        .dir_load (dir_load)
    );

    // stage enables: a stage loads when empty or when its successor loads
    logic en1, en2, en3, en4, en_o;
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;

    assign en_o = !vo_reg || m_tready;
    assign en4  = !v4_reg || en_o;
    assign en3  = !v3_reg || en4;
    assign en2  = !v2_reg || en3;
    assign en1  = !v1_reg || en2;
    assign s_tready = en1;

    // stage 1: input register
    logic signed [ANGLE_W-1:0] ang1_reg;

    // stage 2: error, integrator, history. The stage-2 item's error and sum
    // are exactly prev_error_reg and error_sum_reg.
    logic signed [SUM_WIDTH-1:0] error_sum_reg;
    logic signed [ERR_W-1:0]     prev_error_reg;
    logic signed [ANGLE_W-1:0]   prev_angle_reg;
    logic                        dir_reg, dir_next;
    logic signed [DIFF_W-1:0]    diff2_reg;
    motion_t                     mot2_reg;

    logic signed [ANGLE_W:0]     ang_x, sp_x, sp_lo, sp_hi;
    logic signed [ERR_W-1:0]     err_c;
    logic signed [DIFF_W-1:0]    diff_c;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_sat;
    motion_t                     mot_c;
    logic                        take2;

    assign take2 = v1_reg && en2;
    assign ang_x = {ang1_reg[ANGLE_W-1], ang1_reg};
    assign sp_x  = {{(ANGLE_W+1-SP_W){cfg.setpoint[SP_W-1]}}, cfg.setpoint};
    assign sp_lo = sp_x - (ANGLE_W+1)'(STUCK_BAND);
    assign sp_hi = sp_x + (ANGLE_W+1)'(STUCK_BAND);

    assign err_c    = {sp_x[ANGLE_W], sp_x} - {ang_x[ANGLE_W], ang_x};
    assign diff_c   = {err_c[ERR_W-1], err_c} - {prev_error_reg[ERR_W-1], prev_error_reg};
    assign sum_wide = {error_sum_reg[SUM_WIDTH-1], error_sum_reg}
                    + {{(SUM_WIDTH+1-ERR_W){err_c[ERR_W-1]}}, err_c};

    always_comb begin
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
            sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                          : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SUM_WIDTH-1:0];
        end
    end

    always_comb begin
        priority if (ang_x > sp_x) begin
            dir_next = 1'b0;
        end else if (ang_x < sp_x) begin
            dir_next = 1'b1;
        end else begin
            dir_next = dir_reg;
        end
    end

    always_comb begin
        mot_c.in_band = (ang_x > sp_lo) && (ang_x < sp_hi);
        mot_c.same    = (prev_angle_reg == ang1_reg);
        mot_c.rising  = (prev_angle_reg < ang1_reg);
        mot_c.falling = (prev_angle_reg > ang1_reg);
        mot_c.forward = dir_next;
    end

    // stage 3: gain products
    logic signed [PROD_E_W-1:0] pp3_reg, pp_c;
    logic signed [PROD_I_W-1:0] pi3_reg, pi_c;
    logic signed [PROD_D_W-1:0] pd3_reg, pd_c;
    motion_t                    mot3_reg;

    assign pp_c = $signed({1'b0, cfg.gain_p}) * prev_error_reg;
    assign pi_c = $signed({1'b0, cfg.gain_i}) * error_sum_reg;
    assign pd_c = $signed({1'b0, cfg.gain_d}) * diff2_reg;

    // stage 4: accumulate
    logic signed [ACC_W-1:0] acc4_reg, acc_c;
    motion_t                 mot4_reg;

    assign acc_c = {{(ACC_W-PROD_E_W){pp3_reg[PROD_E_W-1]}}, pp3_reg}
                 + {{(ACC_W-PROD_I_W){pi3_reg[PROD_I_W-1]}}, pi3_reg}
                 + {{(ACC_W-PROD_D_W){pd3_reg[PROD_D_W-1]}}, pd3_reg};

    // output stage: magnitude, clamp, watchdog
    logic [ACC_W-1:0]   acc_abs;
    logic [MAG_W-1:0]   mag;
    logic [DRIVE_W-1:0] drive_c;
    logic               drive_nz;
    logic               stuck_c, wrong_c, step_o;
    logic [DRIVE_W-1:0] drive_o_reg;
    logic               fwd_o_reg, stuck_o_reg, wrong_o_reg;

    assign acc_abs  = acc4_reg[ACC_W-1] ? (-acc4_reg) : acc4_reg;
    assign mag      = acc_abs[ACC_W-1:GAIN_FRAC_BITS];
    assign drive_c  = (mag > {{(MAG_W-DRIVE_W){1'b0}}, cfg.drive_limit})
                    ? cfg.drive_limit : mag[DRIVE_W-1:0];
    assign drive_nz = (drive_c != '0);
    assign step_o   = v4_reg && en_o;

    mapid_wdog u_wdog (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step_o),
        .cfg         (cfg),
        .motion      (mot4_reg),
        .drive_nz    (drive_nz),
        .stuck_alarm (stuck_c),
        .wrong_alarm (wrong_c)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            vo_reg         <= 1'b0;
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
            prev_angle_reg <= '0;
            dir_reg        <= 1'b1;
        end else begin
            if (en1)  v1_reg <= s_tvalid;
            if (en2)  v2_reg <= v1_reg;
            if (en3)  v3_reg <= v2_reg;
            if (en4)  v4_reg <= v3_reg;
            if (en_o) vo_reg <= v4_reg;
            if (take2) begin
                error_sum_reg  <= sum_sat;
                prev_error_reg <= err_c;
                prev_angle_reg <= ang1_reg;
                dir_reg        <= dir_next;
            end else if (dir_load.load) begin
                dir_reg <= dir_load.value;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && en1) begin
            ang1_reg <= s_tdata[ANGLE_W-1:0];
        end
        if (take2) begin
            diff2_reg <= diff_c;
            mot2_reg  <= mot_c;
        end
        if (v2_reg && en3) begin
            pp3_reg  <= pp_c;
            pi3_reg  <= pi_c;
            pd3_reg  <= pd_c;
            mot3_reg <= mot2_reg;
        end
        if (v3_reg && en4) begin
            acc4_reg <= acc_c;
            mot4_reg <= mot3_reg;
        end
        if (step_o) begin
            drive_o_reg <= drive_c;
            fwd_o_reg   <= mot4_reg.forward;
            stuck_o_reg <= stuck_c;
            wrong_o_reg <= wrong_c;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {2'b00, wrong_o_reg, stuck_o_reg, fwd_o_reg, drive_o_reg};

    `MAPID_ASSERT_IMP(a_drive_clamped, aclk, aresetn, vo_reg, drive_o_reg <= cfg.drive_limit)
    `MAPID_ASSERT_IMP(a_full_when_blocked, aclk, aresetn, !s_tready, v1_reg && v2_reg && v3_reg && v4_reg && vo_reg)
    `MAPID_ASSERT_IMP(a_no_stuck_without_drive, aclk, aresetn, vo_reg && (drive_o_reg == '0), !stuck_o_reg)

endmodule
